[design/slbe_pkg.sv]
// shared constants and types for the sigmoid layer training engine
`timescale 1ns / 1ps
package slbe_pkg;

   localparam int IN_NODES   = 16;
   localparam int OUT_NODES  = 16;
   localparam int MAX_REPORT = 16;
   localparam int REP_IN     = (IN_NODES < MAX_REPORT) ? IN_NODES : MAX_REPORT;
   localparam int REP_OUT    = (OUT_NODES < MAX_REPORT) ? OUT_NODES : MAX_REPORT;
   localparam int IN_IDX_W   = (IN_NODES > 1) ? $clog2(IN_NODES) : 1;
   localparam int OUT_IDX_W  = (OUT_NODES > 1) ? $clog2(OUT_NODES) : 1;
   localparam int WA_W       = (IN_NODES * OUT_NODES > 1) ? $clog2(IN_NODES * OUT_NODES) : 1;

   localparam int CMD_W  = 3;
   localparam int NODE_W = 4;
   localparam int DATA_W = 32;
   localparam int LR_W   = 17;

   typedef logic [CMD_W-1:0]         cmd_type;
   typedef logic signed [DATA_W-1:0] q_type;

   localparam cmd_type CMD_WEIGHT = 3'd0;
   localparam cmd_type CMD_BIAS   = 3'd1;
   localparam cmd_type CMD_ACT    = 3'd2;
   localparam cmd_type CMD_FWD    = 3'd3;
   localparam cmd_type CMD_TARGET = 3'd4;
   localparam cmd_type CMD_DELTA  = 3'd5;
   localparam cmd_type CMD_BPROP  = 3'd6;

   localparam logic KIND_ACT = 1'b0;
   localparam logic KIND_ERR = 1'b1;

   localparam logic [LR_W-1:0] LR_RESET = 17'd6554;

   localparam q_type ONE_Q  = 32'sd65536;
   localparam q_type SIG_LO = -32'sd524288;
   localparam q_type SIG_HI = 32'sd524288;

   localparam logic [31:0] EXP_STEP = 32'd4034748382;
   localparam int TAB_DEPTH = 257;
   localparam int TAB_MID   = 128;
   localparam int TAB_W     = 17;
   localparam int TAB_AW    = 9;

endpackage

[design/slbe_channels_if.sv]
// handshake channels: command items, result items and the rate register write
`timescale 1ns / 1ps
interface slbe_req_if;
   logic                          valid;
   logic                          ready;
   logic [slbe_pkg::CMD_W-1:0]    cmd;
   logic [slbe_pkg::NODE_W-1:0]   out_node;
   logic [slbe_pkg::NODE_W-1:0]   in_node;
   logic signed [slbe_pkg::DATA_W-1:0] data_value;

   modport source (output valid, cmd, out_node, in_node, data_value, input ready);
   modport sink (input valid, cmd, out_node, in_node, data_value, output ready);
endinterface

interface slbe_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [slbe_pkg::NODE_W-1:0]   node_index;
   logic signed [slbe_pkg::DATA_W-1:0] result_value;
   logic                          last;

   modport source (output valid, kind, node_index, result_value, last, input ready);
   modport sink (input valid, kind, node_index, result_value, last, output ready);
endinterface

interface slbe_csr_if;
   logic                          valid;
   logic                          ready;
   logic [slbe_pkg::LR_W-1:0]     learn_rate;

   modport source (output valid, learn_rate, input ready);
   modport sink (input valid, learn_rate, output ready);
endinterface

[design/sigmoid_layer_backprop_engine.sv]
// sigmoid layer engine: forward pass, delta from target, back-propagation and weight update
// after reset the sigmoid table is built in 129 steps, with req not ready
// loads of weight, bias, activation and delta are written from idle; target runs T1 to T4
// forward: per output node, read, multiply and accumulate per input, then bias, table
// lookup, interpolation and emit; backprop: per input node, a weight column walk, the
// act x (1 - act) scaling and emit, then per output node the bias and weight update;
// one shared 33x33 multiplier, one weight memory; a stalled result register holds an emit
`timescale 1ns / 1ps
module sigmoid_layer_backprop_engine (
   input  logic       clock,
   input  logic       reset,
   slbe_req_if.sink   req_ch,
   slbe_rsp_if.source rsp_ch,
   slbe_csr_if.sink   csr_ch
);

   localparam logic [5:0] ST_TB_INIT = 6'd0;
   localparam logic [5:0] ST_TB_DIV  = 6'd1;
   localparam logic [5:0] ST_TB_W0   = 6'd2;
   localparam logic [5:0] ST_TB_W1   = 6'd3;
   localparam logic [5:0] ST_TB_MUL  = 6'd4;
   localparam logic [5:0] ST_TB_E    = 6'd5;
   localparam logic [5:0] ST_IDLE    = 6'd6;
   localparam logic [5:0] ST_F_RD    = 6'd7;
   localparam logic [5:0] ST_F_MUL   = 6'd8;
   localparam logic [5:0] ST_F_ACC   = 6'd9;
   localparam logic [5:0] ST_F_BIAS  = 6'd10;
   localparam logic [5:0] ST_S_RD0   = 6'd11;
   localparam logic [5:0] ST_S_RD1   = 6'd12;
   localparam logic [5:0] ST_S_MUL   = 6'd13;
   localparam logic [5:0] ST_S_Y     = 6'd14;
   localparam logic [5:0] ST_F_OUT   = 6'd15;
   localparam logic [5:0] ST_B_RD    = 6'd16;
   localparam logic [5:0] ST_B_MUL   = 6'd17;
   localparam logic [5:0] ST_B_ACC   = 6'd18;
   localparam logic [5:0] ST_B_E1    = 6'd19;
   localparam logic [5:0] ST_B_E2    = 6'd20;
   localparam logic [5:0] ST_B_E3    = 6'd21;
   localparam logic [5:0] ST_B_E4    = 6'd22;
   localparam logic [5:0] ST_B_OUT   = 6'd23;
   localparam logic [5:0] ST_U_RD    = 6'd24;
   localparam logic [5:0] ST_U_RD2   = 6'd25;
   localparam logic [5:0] ST_U_WRD   = 6'd26;
   localparam logic [5:0] ST_U_WMUL  = 6'd27;
   localparam logic [5:0] ST_U_WWR   = 6'd28;
   localparam logic [5:0] ST_T1      = 6'd29;
   localparam logic [5:0] ST_T2      = 6'd30;
   localparam logic [5:0] ST_T3      = 6'd31;
   localparam logic [5:0] ST_T4      = 6'd32;

   localparam int IW = slbe_pkg::IN_IDX_W;
   localparam int OW = slbe_pkg::OUT_IDX_W;
   localparam int AW = slbe_pkg::WA_W;
   localparam int TW = slbe_pkg::TAB_W;
   localparam int TA = slbe_pkg::TAB_AW;

   function automatic logic signed [32:0] sx(input slbe_pkg::q_type v);
      return {v[31], v};
   endfunction

   function automatic slbe_pkg::q_type mulq(input logic signed [65:0] p);
      logic signed [65:0] s;
      s = p >>> 16;
      if (s[65:31] == {35{1'b0}} || s[65:31] == {35{1'b1}}) return s[31:0];
      else if (s[65]) return 32'sh8000_0000;
      else return 32'sh7FFF_FFFF;
   endfunction

   function automatic slbe_pkg::q_type sat_fix(input logic signed [32:0] s);
      if (s[32] == s[31]) return s[31:0];
      else if (s[32]) return 32'sh8000_0000;
      else return 32'sh7FFF_FFFF;
   endfunction

   function automatic slbe_pkg::q_type sat_add(input slbe_pkg::q_type a, input slbe_pkg::q_type b);
      return sat_fix(sx(a) + sx(b));
   endfunction

   function automatic slbe_pkg::q_type sat_sub(input slbe_pkg::q_type a, input slbe_pkg::q_type b);
      return sat_fix(sx(a) - sx(b));
   endfunction

   // storage
   logic signed [31:0] wmem [slbe_pkg::IN_NODES * slbe_pkg::OUT_NODES];
   logic [TW-1:0]      tab [slbe_pkg::TAB_DEPTH];
   slbe_pkg::q_type    bias_ff [slbe_pkg::OUT_NODES];
   slbe_pkg::q_type    act_ff [slbe_pkg::IN_NODES];
   slbe_pkg::q_type    yact_ff [slbe_pkg::OUT_NODES];
   slbe_pkg::q_type    delta_ff [slbe_pkg::OUT_NODES];

   logic signed [31:0] wmem_q_ff;
   logic [TW-1:0]      tab_q_ff;

   logic [5:0]         state_ff, state_in;
   logic [OW-1:0]      o_ff, o_in;
   logic [IW-1:0]      i_ff, i_in;
   logic [AW-1:0]      waddr_ff, waddr_in;
   slbe_pkg::q_type    acc_ff, acc_in;
   slbe_pkg::q_type    rd_ff, rd_in;
   logic [TW-1:0]      lo_ff, lo_in;
   logic [TA-1:0]      k1_ff, k1_in;
   logic [11:0]        f_ff, f_in;
   logic [OW-1:0]      on_ff, on_in;
   slbe_pkg::q_type    dv_ff, dv_in;
   logic signed [65:0] prod_ff, prod_in;
   logic [32:0]        e_ff, e_in;
   logic [7:0]         j_ff, j_in;
   logic [48:0]        num_ff, num_in;
   logic [33:0]        rem_ff, rem_in;
   logic [33:0]        den_ff, den_in;
   logic [TW-1:0]      q_ff, q_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [slbe_pkg::LR_W-1:0] learn_rate_ff, learn_rate_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff, rsp_kind_in;
   logic [slbe_pkg::NODE_W-1:0] rsp_node_ff, rsp_node_in;
   slbe_pkg::q_type     rsp_value_ff, rsp_value_in;
   logic                rsp_last_ff, rsp_last_in;

   // write strobes and addresses
   logic                wmem_we;
   logic [AW-1:0]       wmem_wa;
   slbe_pkg::q_type     wmem_wd;
   logic                tab_we;
   logic [TA-1:0]       tab_wa, tab_ra;
   logic [TW-1:0]       tab_wd;
   logic                bias_we, act_we, yact_we, delta_we;
   logic [OW-1:0]       bias_wa, yact_wa, delta_wa;
   logic [IW-1:0]       act_wa;
   slbe_pkg::q_type     bias_wd, act_wd, yact_wd, delta_wd;

   logic signed [32:0]  mul_a, mul_b;
   logic                out_free;
   logic                req_fire;

   logic [33:0]         den_w;
   logic [48:0]         num_w;
   logic [34:0]         r2;
   logic [64:0]         e_round;
   slbe_pkg::q_type     u;
   logic [TA-1:0]       k_w;
   logic signed [17:0]  tdiff;
   logic signed [65:0]  frac;
   logic                o_last, i_last;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && (state_ff == ST_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign o_last       = (o_ff == OW'(slbe_pkg::OUT_NODES - 1));
   assign i_last       = (i_ff == IW'(slbe_pkg::IN_NODES - 1));

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.kind         = rsp_kind_ff;
   assign rsp_ch.node_index   = rsp_node_ff;
   assign rsp_ch.result_value = rsp_value_ff;
   assign rsp_ch.last         = rsp_last_ff;

   assign prod_in = mul_a * mul_b;

   always_comb begin
      state_in      = state_ff;
      o_in          = o_ff;
      i_in          = i_ff;
      waddr_in      = waddr_ff;
      acc_in        = acc_ff;
      rd_in         = rd_ff;
      lo_in         = lo_ff;
      k1_in         = k1_ff;
      f_in          = f_ff;
      on_in         = on_ff;
      dv_in         = dv_ff;
      e_in          = e_ff;
      j_in          = j_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      q_in          = q_ff;
      cnt_in        = cnt_ff;
      learn_rate_in = (csr_ch.valid) ? csr_ch.learn_rate : learn_rate_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      mul_a         = '0;
      mul_b         = '0;
      wmem_we       = 1'b0;
      wmem_wa       = waddr_ff;
      wmem_wd       = '0;
      tab_we        = 1'b0;
      tab_wa        = '0;
      tab_wd        = q_ff;
      tab_ra        = k1_ff;
      bias_we       = 1'b0;
      bias_wa       = o_ff;
      bias_wd       = '0;
      act_we        = 1'b0;
      act_wa        = IW'(req_ch.in_node);
      act_wd        = req_ch.data_value;
      yact_we       = 1'b0;
      yact_wa       = o_ff;
      yact_wd       = acc_ff;
      delta_we      = 1'b0;
      delta_wa      = o_ff;
      delta_wd      = '0;
      den_w         = 34'(e_ff) + 34'h1_0000_0000;
      num_w         = {e_ff, 16'b0} + 49'(den_w >> 1);
      r2            = {rem_ff, num_ff[16]};
      e_round       = prod_ff[64:0] + 65'h8000_0000;
      u             = acc_ff - slbe_pkg::SIG_LO;
      k_w           = '0;
      tdiff         = $signed({1'b0, tab_q_ff}) - $signed({1'b0, lo_ff});
      frac          = prod_ff >>> 12;

      case (state_ff)
         // sigmoid table build
         ST_TB_INIT: begin
            den_in   = den_w;
            num_in   = num_w;
            rem_in   = 34'(num_w[48:17]);
            cnt_in   = '0;
            state_in = ST_TB_DIV;
         end
         ST_TB_DIV: begin
            if (r2 >= 35'(den_ff)) begin
               rem_in = 34'(r2 - 35'(den_ff));
               q_in   = {q_ff[TW-2:0], 1'b1};
            end else begin
               rem_in = r2[33:0];
               q_in   = {q_ff[TW-2:0], 1'b0};
            end
            num_in = {num_ff[47:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(TW - 1)) state_in = ST_TB_W0;
         end
         ST_TB_W0: begin
            tab_we   = 1'b1;
            tab_wa   = TA'(slbe_pkg::TAB_MID) - TA'(j_ff);
            tab_wd   = q_ff;
            state_in = ST_TB_W1;
         end
         ST_TB_W1: begin
            tab_we   = 1'b1;
            tab_wa   = TA'(slbe_pkg::TAB_MID) + TA'(j_ff);
            tab_wd   = TW'(slbe_pkg::ONE_Q) - q_ff;
            state_in = ST_TB_MUL;
         end
         ST_TB_MUL: begin
            mul_a    = {1'b0, e_ff[31:0]};
            mul_b    = {1'b0, slbe_pkg::EXP_STEP};
            state_in = ST_TB_E;
         end
         ST_TB_E: begin
            // e of exactly 1.0 only occurs on the first step
            e_in = e_ff[32] ? {1'b0, slbe_pkg::EXP_STEP} : e_round[64:32];
            if (j_ff == 8'(slbe_pkg::TAB_MID)) begin
               state_in = ST_IDLE;
            end else begin
               j_in     = j_ff + 8'd1;
               state_in = ST_TB_INIT;
            end
         end
         ST_IDLE: begin
            o_in     = '0;
            i_in     = '0;
            waddr_in = '0;
            acc_in   = '0;
            on_in    = OW'(req_ch.out_node);
            dv_in    = req_ch.data_value;
            if (req_fire) begin
               case (req_ch.cmd)
                  slbe_pkg::CMD_WEIGHT: begin
                     if (32'(req_ch.out_node) < 32'(slbe_pkg::OUT_NODES) &&
                         32'(req_ch.in_node) < 32'(slbe_pkg::IN_NODES)) begin
                        wmem_we = 1'b1;
                        wmem_wa = AW'(32'(req_ch.out_node) * slbe_pkg::IN_NODES +
                                      32'(req_ch.in_node));
                        wmem_wd = req_ch.data_value;
                     end
                  end
                  slbe_pkg::CMD_BIAS: begin
                     bias_we = (32'(req_ch.out_node) < 32'(slbe_pkg::OUT_NODES));
                     bias_wa = OW'(req_ch.out_node);
                     bias_wd = req_ch.data_value;
                  end
                  slbe_pkg::CMD_ACT: begin
                     act_we = (32'(req_ch.in_node) < 32'(slbe_pkg::IN_NODES));
                  end
                  slbe_pkg::CMD_FWD: state_in = ST_F_RD;
                  slbe_pkg::CMD_TARGET: begin
                     if (32'(req_ch.out_node) < 32'(slbe_pkg::OUT_NODES)) state_in = ST_T1;
                  end
                  slbe_pkg::CMD_DELTA: begin
                     delta_we = (32'(req_ch.out_node) < 32'(slbe_pkg::OUT_NODES));
                     delta_wa = OW'(req_ch.out_node);
                     delta_wd = req_ch.data_value;
                  end
                  slbe_pkg::CMD_BPROP: state_in = ST_B_RD;
                  default: ;
               endcase
            end
         end
         // forward pass
         ST_F_RD: state_in = ST_F_MUL;
         ST_F_MUL: begin
            mul_a    = sx(wmem_q_ff);
            mul_b    = sx(act_ff[i_ff]);
            state_in = ST_F_ACC;
         end
         ST_F_ACC: begin
            acc_in   = sat_add(acc_ff, mulq(prod_ff));
            waddr_in = waddr_ff + AW'(1);
            if (i_last) begin
               i_in     = '0;
               state_in = ST_F_BIAS;
            end else begin
               i_in     = i_ff + IW'(1);
               state_in = ST_F_RD;
            end
         end
         ST_F_BIAS: begin
            acc_in   = sat_add(acc_ff, bias_ff[o_ff]);
            state_in = ST_S_RD0;
         end
         ST_S_RD0: begin
            if (acc_ff < slbe_pkg::SIG_LO) begin
               k_w  = '0;
               f_in = '0;
            end else if (acc_ff >= slbe_pkg::SIG_HI) begin
               k_w  = TA'(slbe_pkg::TAB_DEPTH - 1);
               f_in = '0;
            end else begin
               k_w  = {1'b0, u[19:12]};
               f_in = u[11:0];
            end
            tab_ra   = k_w;
            k1_in    = (k_w == TA'(slbe_pkg::TAB_DEPTH - 1)) ? k_w : k_w + TA'(1);
            state_in = ST_S_RD1;
         end
         ST_S_RD1: begin
            lo_in    = tab_q_ff;
            tab_ra   = k1_ff;
            state_in = ST_S_MUL;
         end
         ST_S_MUL: begin
            mul_a    = {{15{tdiff[17]}}, tdiff};
            mul_b    = {21'b0, f_ff};
            state_in = ST_S_Y;
         end
         ST_S_Y: begin
            acc_in   = $signed({15'b0, lo_ff}) + frac[31:0];
            state_in = ST_F_OUT;
         end
         ST_F_OUT: begin
            if (32'(o_ff) >= 32'(slbe_pkg::MAX_REPORT) || out_free) begin
               yact_we = 1'b1;
               if (32'(o_ff) < 32'(slbe_pkg::MAX_REPORT)) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = slbe_pkg::KIND_ACT;
                  rsp_node_in  = slbe_pkg::NODE_W'(o_ff);
                  rsp_value_in = acc_ff;
                  rsp_last_in  = (32'(o_ff) == 32'(slbe_pkg::REP_OUT - 1));
               end
               acc_in = '0;
               if (o_last) begin
                  state_in = ST_IDLE;
               end else begin
                  o_in     = o_ff + OW'(1);
                  state_in = ST_F_RD;
               end
            end
         end
         // input errors, walking one weight column per input node
         ST_B_RD: state_in = ST_B_MUL;
         ST_B_MUL: begin
            mul_a    = sx(delta_ff[o_ff]);
            mul_b    = sx(wmem_q_ff);
            state_in = ST_B_ACC;
         end
         ST_B_ACC: begin
            acc_in = sat_add(acc_ff, mulq(prod_ff));
            if (o_last) begin
               o_in     = '0;
               state_in = ST_B_E1;
            end else begin
               o_in     = o_ff + OW'(1);
               waddr_in = waddr_ff + AW'(slbe_pkg::IN_NODES);
               state_in = ST_B_RD;
            end
         end
         ST_B_E1: begin
            mul_a    = sx(acc_ff);
            mul_b    = sx(act_ff[i_ff]);
            state_in = ST_B_E2;
         end
         ST_B_E2: begin
            acc_in   = mulq(prod_ff);
            state_in = ST_B_E3;
         end
         ST_B_E3: begin
            mul_a    = sx(acc_ff);
            mul_b    = sx(sat_sub(slbe_pkg::ONE_Q, act_ff[i_ff]));
            state_in = ST_B_E4;
         end
         ST_B_E4: begin
            acc_in   = mulq(prod_ff);
            state_in = ST_B_OUT;
         end
         ST_B_OUT: begin
            if (32'(i_ff) >= 32'(slbe_pkg::MAX_REPORT) || out_free) begin
               if (32'(i_ff) < 32'(slbe_pkg::MAX_REPORT)) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = slbe_pkg::KIND_ERR;
                  rsp_node_in  = slbe_pkg::NODE_W'(i_ff);
                  rsp_value_in = acc_ff;
                  rsp_last_in  = (32'(i_ff) == 32'(slbe_pkg::REP_IN - 1));
               end
               acc_in = '0;
               if (i_last) begin
                  i_in     = '0;
                  waddr_in = '0;
                  state_in = ST_U_RD;
               end else begin
                  i_in     = i_ff + IW'(1);
                  waddr_in = AW'(i_ff) + AW'(1);
                  state_in = ST_B_RD;
               end
            end
         end
         // weight and bias update
         ST_U_RD: begin
            mul_a    = {16'b0, learn_rate_ff};
            mul_b    = sx(delta_ff[o_ff]);
            state_in = ST_U_RD2;
         end
         ST_U_RD2: begin
            rd_in    = mulq(prod_ff);
            bias_we  = 1'b1;
            bias_wd  = sat_sub(bias_ff[o_ff], mulq(prod_ff));
            state_in = ST_U_WRD;
         end
         ST_U_WRD: state_in = ST_U_WMUL;
         ST_U_WMUL: begin
            mul_a    = sx(rd_ff);
            mul_b    = sx(act_ff[i_ff]);
            state_in = ST_U_WWR;
         end
         ST_U_WWR: begin
            // memory output still holds the old weight at this address
            wmem_we  = 1'b1;
            wmem_wd  = sat_sub(wmem_q_ff, mulq(prod_ff));
            waddr_in = waddr_ff + AW'(1);
            if (i_last) begin
               i_in = '0;
               if (o_last) begin
                  state_in = ST_IDLE;
               end else begin
                  o_in     = o_ff + OW'(1);
                  state_in = ST_U_RD;
               end
            end else begin
               i_in     = i_ff + IW'(1);
               state_in = ST_U_WRD;
            end
         end
         // delta from target
         ST_T1: begin
            mul_a    = sx(sat_sub(yact_ff[on_ff], dv_ff));
            mul_b    = sx(yact_ff[on_ff]);
            state_in = ST_T2;
         end
         ST_T2: begin
            acc_in   = mulq(prod_ff);
            state_in = ST_T3;
         end
         ST_T3: begin
            mul_a    = sx(acc_ff);
            mul_b    = sx(sat_sub(slbe_pkg::ONE_Q, yact_ff[on_ff]));
            state_in = ST_T4;
         end
         ST_T4: begin
            delta_we = 1'b1;
            delta_wa = on_ff;
            delta_wd = mulq(prod_ff);
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_TB_INIT;
         e_ff          <= 33'h1_0000_0000;
         j_ff          <= '0;
         learn_rate_ff <= slbe_pkg::LR_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         e_ff          <= e_in;
         j_ff          <= j_in;
         learn_rate_ff <= learn_rate_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      o_ff         <= o_in;
      i_ff         <= i_in;
      waddr_ff     <= waddr_in;
      acc_ff       <= acc_in;
      rd_ff        <= rd_in;
      lo_ff        <= lo_in;
      k1_ff        <= k1_in;
      f_ff         <= f_in;
      on_ff        <= on_in;
      dv_ff        <= dv_in;
      prod_ff      <= prod_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      q_ff         <= q_in;
      cnt_ff       <= cnt_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wmem_we) wmem[wmem_wa] <= wmem_wd;
      wmem_q_ff <= wmem[waddr_ff];
   end

   always_ff @(posedge clock) begin
      if (tab_we) tab[tab_wa] <= tab_wd;
      tab_q_ff <= tab[tab_ra];
   end

   always_ff @(posedge clock) begin
      if (bias_we) bias_ff[bias_wa] <= bias_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < slbe_pkg::IN_NODES; n++) act_ff[n] <= '0;
         for (int n = 0; n < slbe_pkg::OUT_NODES; n++) begin
            yact_ff[n]  <= '0;
            delta_ff[n] <= '0;
         end
      end else begin
         if (act_we) act_ff[act_wa] <= act_wd;
         if (yact_we) yact_ff[yact_wa] <= yact_wd;
         if (delta_we) delta_ff[delta_wa] <= delta_wd;
      end
   end

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_F_OUT || state_ff == ST_B_OUT))
      else $error("result appeared outside an emit step");

   a_fwd_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_ch.cmd == slbe_pkg::CMD_FWD) |=> (state_ff == ST_F_RD))
      else $error("forward item did not start a run");

   a_fwd_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff && rsp_kind_ff == slbe_pkg::KIND_ACT) |->
      (rsp_node_ff == slbe_pkg::NODE_W'(slbe_pkg::REP_OUT - 1)))
      else $error("last flag on wrong forward node");

   a_tab_bound: assert property (@(posedge clock) disable iff (reset)
      (j_ff <= 8'(slbe_pkg::TAB_MID)))
      else $error("table build step out of range");

endmodule
